// ===== rtl/core/cde_pkg.sv =====
// Shared types and constants for the circular deque engine.
// No dependencies; imported by every module of the block except cde_ram.
package cde_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OP_WIDTH     = 3;
   localparam int POS_WIDTH    = 4;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int FILL_WIDTH   = 5;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_WRITE_AT   = 3'd5,
      OP_REMOVE_AT  = 3'd6
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Decoded command as it travels from the pointer stage to the data stage.
   typedef struct packed {
      logic                  ret_data;    // value_out comes from the slot read
      logic                  wr_en;       // one slot is written in the data stage
      logic                  wr_from_rd;  // write data is the slot just read
      status_type            status;
      logic [FILL_WIDTH-1:0] fill;
   } stage_ctl_type;

endpackage

// ===== rtl/core/cde_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same slot is written in that cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cde_ctrl.sv =====
// Pointer stage of the deque: head slot and occupancy, command decode,
// wrapped slot addresses. Depends on cde_pkg.
module cde_ctrl
   import cde_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        cmd_valid,
   input  op_type                      cmd_op,
   input  logic [POS_WIDTH-1:0]        cmd_position,
   output logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output stage_ctl_type               ctl
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > POS_WIDTH) ? CW : POS_WIDTH;
   localparam int SW = MW + 1;
   localparam int FW = (MW > FILL_WIDTH) ? MW : FILL_WIDTH;
   localparam logic [AW-1:0] HEAD_RESET = AW'(CAPACITY / 4);
   localparam logic [AW-1:0] HEAD_LAST  = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] OCC_MAX    = CW'(CAPACITY);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [AW-1:0] head_dec, head_inc;
   logic [AW-1:0] slot_tail, slot_back, slot_pos;
   logic [CW-1:0] occ_last;
   logic          is_full, is_empty, pos_bad, pos_is_last;
   logic [FW-1:0] fill_wide;

   // (base + offset) mod CAPACITY; the sum always stays below twice the capacity
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [MW-1:0] offset);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(offset);
      if (sum >= SW'(CAPACITY)) begin
         sum = sum - SW'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   assign occ_last    = occ_ff - CW'(1);
   assign is_full     = (occ_ff == OCC_MAX);
   assign is_empty    = (occ_ff == '0);
   assign pos_bad     = (MW'(cmd_position) >= MW'(occ_ff));
   assign pos_is_last = (MW'(cmd_position) == MW'(occ_last));
   assign head_dec    = (head_ff == '0) ? HEAD_LAST : head_ff - AW'(1);
   assign head_inc    = (head_ff == HEAD_LAST) ? '0 : head_ff + AW'(1);
   assign slot_tail   = wrap_add(head_ff, MW'(occ_ff));
   assign slot_back   = wrap_add(head_ff, MW'(occ_last));
   assign slot_pos    = wrap_add(head_ff, MW'(cmd_position));

   always_comb begin
      head_in        = head_ff;
      occ_in         = occ_ff;
      rd_addr        = head_ff;
      wr_addr        = head_ff;
      ctl.ret_data   = 1'b0;
      ctl.wr_en      = 1'b0;
      ctl.wr_from_rd = 1'b0;
      ctl.status     = ST_OK;
      unique case (cmd_op) inside
         OP_PUSH_BACK: begin
            if (is_full) begin
               ctl.status = ST_FULL;
            end else begin
               wr_addr   = slot_tail;
               ctl.wr_en = 1'b1;
               occ_in    = occ_ff + CW'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (is_full) begin
               ctl.status = ST_FULL;
            end else begin
               head_in   = head_dec;
               wr_addr   = head_dec;
               ctl.wr_en = 1'b1;
               occ_in    = occ_ff + CW'(1);
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               ctl.status = ST_EMPTY;
            end else begin
               rd_addr      = slot_back;
               ctl.ret_data = 1'b1;
               occ_in       = occ_last;
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               ctl.status = ST_EMPTY;
            end else begin
               rd_addr      = head_ff;
               ctl.ret_data = 1'b1;
               head_in      = head_inc;
               occ_in       = occ_last;
            end
         end
         OP_READ_AT, OP_WRITE_AT, OP_REMOVE_AT: begin
            if (is_empty) begin
               ctl.status = ST_EMPTY;
            end else if (pos_bad) begin
               ctl.status = ST_RANGE;
            end else if (cmd_op == OP_READ_AT) begin
               rd_addr      = slot_pos;
               ctl.ret_data = 1'b1;
            end else if (cmd_op == OP_WRITE_AT) begin
               wr_addr   = slot_pos;
               ctl.wr_en = 1'b1;
            end else begin
               // move the last element into the hole; value_out stays zero
               rd_addr = slot_back;
               wr_addr = slot_pos;
               if (!pos_is_last) begin
                  ctl.wr_en      = 1'b1;
                  ctl.wr_from_rd = 1'b1;
               end
               occ_in = occ_last;
            end
         end
         default: begin
         end
      endcase
      fill_wide = FW'(occ_in);
      ctl.fill  = fill_wide[FILL_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         occ_ff  <= '0;
      end else if (advance && cmd_valid) begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) occ_ff <= OCC_MAX)
      else $error("occupancy above capacity");

   assert property (@(posedge clock) disable iff (reset) head_ff <= HEAD_LAST)
      else $error("head slot out of range");

   assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_valid && ctl.status == ST_OK &&
       (cmd_op == OP_PUSH_BACK || cmd_op == OP_PUSH_FRONT))
      |=> (occ_ff == $past(occ_ff) + CW'(1)))
      else $error("accepted push did not grow the queue");

endmodule

// ===== rtl/core/circular_deque_engine_unit.sv =====
// Top level of the circular deque engine: command register, pointer stage,
// slot RAM, data stage and result register. Depends on cde_pkg, cde_ctrl, cde_ram.
//
// Usage:
//   Commands arrive on req_* (op, position, value_in) with valid/ready; each
//   command gives exactly one result beat on rsp_* (value_out, status,
//   fill_count), in command order.
//   Order: the accepting edge loads the command register; the slot read
//   (registered in the RAM) and the data stage registers are loaded after
//   it, then the result register, whose contents show on rsp_*.
//   Throughput: one command per cycle while no stall holds the pipe. Head
//   and occupancy update in the pointer stage; every slot write happens one
//   stage later on the single RAM write port, and a read of a slot written
//   by the command just ahead takes the data from a forwarding register.
//   Reset: the queue is empty and the head slot sits at CAPACITY/4; slot
//   contents are left as they are and are never read before being written.
//   Stall: while a result waits with rsp_ready low the whole pipe holds and
//   req_ready is low; nothing is lost or repeated.
module circular_deque_engine_unit
   import cde_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OP_WIDTH-1:0]     req_op,
   input  logic [POS_WIDTH-1:0]    req_position,
   input  logic [VALUE_WIDTH-1:0]  req_value_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [VALUE_WIDTH-1:0]  rsp_value_out,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic [FILL_WIDTH-1:0]   rsp_fill_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int XW = (DATA_WIDTH > VALUE_WIDTH) ? DATA_WIDTH : VALUE_WIDTH;

   logic                   advance;

   // command register
   logic                   s1_valid_ff;
   op_type                 s1_op_ff;
   logic [POS_WIDTH-1:0]   s1_pos_ff;
   logic [DATA_WIDTH-1:0]  s1_val_ff;
   logic [XW-1:0]          req_val_wide;

   // pointer stage outputs
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   stage_ctl_type          ctl;

   // data stage
   logic                   s2_valid_ff;
   stage_ctl_type          s2_ctl_ff;
   logic [AW-1:0]          s2_wr_addr_ff;
   logic [DATA_WIDTH-1:0]  s2_val_ff;
   logic                   s2_fwd_ff;
   logic [DATA_WIDTH-1:0]  s2_fwd_data_ff;
   logic [DATA_WIDTH-1:0]  ram_rd_data;
   logic [DATA_WIDTH-1:0]  s2_rd_data;
   logic [DATA_WIDTH-1:0]  s2_wr_data;
   logic                   s2_wr_en;
   logic [XW-1:0]          s2_out_wide;

   // result register
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   status_type             rsp_status_ff;
   logic [FILL_WIDTH-1:0]  rsp_fill_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign req_val_wide = XW'(req_value_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         s1_op_ff  <= op_type'(req_op);
         s1_pos_ff <= req_position;
         s1_val_ff <= req_val_wide[DATA_WIDTH-1:0];
      end
   end

   cde_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cmd_valid   (s1_valid_ff),
      .cmd_op      (s1_op_ff),
      .cmd_position(s1_pos_ff),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .ctl         (ctl)
   );

   // forwarded data wins over the RAM when the command ahead wrote this slot
   assign s2_rd_data = s2_fwd_ff ? s2_fwd_data_ff : ram_rd_data;
   assign s2_wr_data = s2_ctl_ff.wr_from_rd ? s2_rd_data : s2_val_ff;
   assign s2_wr_en   = advance && s2_valid_ff && s2_ctl_ff.wr_en;

   cde_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(CAPACITY)
   ) u_slots (
      .clock  (clock),
      .wr_en  (s2_wr_en),
      .wr_addr(s2_wr_addr_ff),
      .wr_data(s2_wr_data),
      .rd_en  (advance),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_fwd_ff   <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
         s2_fwd_ff   <= s2_wr_en && (s2_wr_addr_ff == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ctl_ff      <= ctl;
         s2_wr_addr_ff  <= wr_addr;
         s2_val_ff      <= s1_val_ff;
         s2_fwd_data_ff <= s2_wr_data;
      end
   end

   assign s2_out_wide = s2_ctl_ff.ret_data ? XW'(s2_rd_data) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff  <= s2_out_wide[VALUE_WIDTH-1:0];
         rsp_status_ff <= s2_ctl_ff.status;
         rsp_fill_ff   <= s2_ctl_ff.fill;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

// ===== tb/deque_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for circular_deque_engine_unit: watches both channels, predicts each
// result from its own deque model and compares every rsp beat. Depends on cde_pkg.
module deque_result_checker
   import cde_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [OP_WIDTH-1:0]     req_op,
   input  logic [POS_WIDTH-1:0]    req_position,
   input  logic [VALUE_WIDTH-1:0]  req_value_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [VALUE_WIDTH-1:0]  rsp_value_out,
   input  logic [STATUS_WIDTH-1:0] rsp_status,
   input  logic [FILL_WIDTH-1:0]   rsp_fill_count,
   output int                      fault_count,
   output int                      pending_count
);

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      status_type             status;
      logic [FILL_WIDTH-1:0]  fill;
   } deque_result_type;

   logic [VALUE_WIDTH-1:0] slot_data [CAPACITY_DEFAULT];
   logic [POS_WIDTH-1:0]   head_ptr;
   logic [FILL_WIDTH-1:0]  depth;
   deque_result_type       awaited_results [$];
   int                     rsp_beats;

   initial begin
      fault_count   = 0;
      pending_count = 0;
      rsp_beats     = 0;
   end

   // Physical slot of a logical index; the 4-bit sum wraps around the ring.
   function automatic logic [POS_WIDTH-1:0] slot_of(input logic [FILL_WIDTH-1:0] logical);
      return head_ptr + logical[POS_WIDTH-1:0];
   endfunction

   function automatic deque_result_type run_deque_command(input logic [OP_WIDTH-1:0] op_bits,
                                                          input logic [POS_WIDTH-1:0] pos,
                                                          input logic [VALUE_WIDTH-1:0] val);
      deque_result_type r;
      r.value  = '0;
      r.status = ST_OK;
      case (op_type'(op_bits)) inside
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (depth >= CAPACITY_DEFAULT) begin
               r.status = ST_FULL;
            end else if (op_type'(op_bits) == OP_PUSH_BACK) begin
               slot_data[slot_of(depth)] = val;
               depth = depth + 1'b1;
            end else begin
               head_ptr = head_ptr - 1'b1;
               slot_data[head_ptr] = val;
               depth = depth + 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (depth == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = slot_data[slot_of(depth - 1'b1)];
               depth = depth - 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (depth == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = slot_data[head_ptr];
               head_ptr = head_ptr + 1'b1;
               depth = depth - 1'b1;
            end
         end
         OP_READ_AT, OP_WRITE_AT, OP_REMOVE_AT: begin
            if (depth == 0) begin
               r.status = ST_EMPTY;
            end else if ({1'b0, pos} >= depth) begin
               r.status = ST_RANGE;
            end else if (op_type'(op_bits) == OP_READ_AT) begin
               r.value = slot_data[slot_of({1'b0, pos})];
            end else if (op_type'(op_bits) == OP_WRITE_AT) begin
               slot_data[slot_of({1'b0, pos})] = val;
            end else begin
               // move the last element into the hole unless it is the hole
               if ({1'b0, pos} != depth - 1'b1)
                  slot_data[slot_of({1'b0, pos})] = slot_data[slot_of(depth - 1'b1)];
               depth = depth - 1'b1;
            end
         end
         default: ;
      endcase
      r.fill = depth;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] got,
                                  input logic [VALUE_WIDTH-1:0] want);
      $display("[%0t] rsp beat %0d: %s got %h want %h", $time, rsp_beats, what, got, want);
      fault_count++;
   endtask

   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         foreach (slot_data[i]) slot_data[i] = '0;
         head_ptr = POS_WIDTH'(CAPACITY_DEFAULT / 4);
         depth    = '0;
         awaited_results.delete();
      end else begin
         // retire the oldest expectation before queuing a new one
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected beat, value", rsp_value_out, '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_value_out !== want.value)
                  report_mismatch("value_out", rsp_value_out, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", VALUE_WIDTH'(rsp_status),
                                  VALUE_WIDTH'(want.status));
               if (rsp_fill_count !== want.fill)
                  report_mismatch("fill_count", VALUE_WIDTH'(rsp_fill_count),
                                  VALUE_WIDTH'(want.fill));
            end
            rsp_beats++;
         end
         if (req_valid && req_ready)
            awaited_results.push_back(run_deque_command(req_op, req_position, req_value_in));
      end
      pending_count = awaited_results.size();
   end

endmodule

// ===== tb/circular_deque_engine_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the deque engine testbench: clock, reset, command stimulus, rsp back-pressure
// and verdict. Depends on cde_pkg, circular_deque_engine_unit and deque_result_checker.
module circular_deque_engine_unit_test
   import cde_pkg::*;
();

   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 480;

   logic                    clock;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic [OP_WIDTH-1:0]     req_op         = '0;
   logic [POS_WIDTH-1:0]    req_position   = '0;
   logic [VALUE_WIDTH-1:0]  req_value_in   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic [VALUE_WIDTH-1:0]  rsp_value_out;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic [FILL_WIDTH-1:0]   rsp_fill_count;

   int fault_count;
   int pending_count;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_requests   = 0;
   int holds_done      = 0;
   int fill_estimate   = 0;
   int idle_cycles     = 0;

   circular_deque_engine_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_fill_count(rsp_fill_count)
   );

   deque_result_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_fill_count(rsp_fill_count),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one beat; return at the edge where it is taken.
   task automatic send_command(input op_type op, input logic [POS_WIDTH-1:0] pos,
                               input logic [VALUE_WIDTH-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_position <= pos;
      req_value_in <= val;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      // track occupancy only to steer positions and push/pop balance
      case (op) inside
         OP_PUSH_BACK, OP_PUSH_FRONT:
            if (fill_estimate < CAPACITY_DEFAULT) fill_estimate++;
         OP_POP_BACK, OP_POP_FRONT:
            if (fill_estimate > 0) fill_estimate--;
         OP_REMOVE_AT:
            if (pos < fill_estimate) fill_estimate--;
         default: ;
      endcase
   endtask

   task automatic send_random(input int trend);
      int            roll;
      op_type        op;
      logic [POS_WIDTH-1:0]   pos;
      logic [VALUE_WIDTH-1:0] val;
      roll = $urandom_range(0, 99);
      if (trend == 0) begin
         // grow toward full
         op = roll < 35 ? OP_PUSH_BACK : roll < 60 ? OP_PUSH_FRONT :
              roll < 70 ? OP_POP_BACK : roll < 78 ? OP_POP_FRONT :
              roll < 86 ? OP_READ_AT : roll < 94 ? OP_WRITE_AT : OP_REMOVE_AT;
      end else if (trend == 1) begin
         // drain toward empty
         op = roll < 8 ? OP_PUSH_BACK : roll < 16 ? OP_PUSH_FRONT :
              roll < 40 ? OP_POP_BACK : roll < 64 ? OP_POP_FRONT :
              roll < 76 ? OP_READ_AT : roll < 84 ? OP_WRITE_AT : OP_REMOVE_AT;
      end else begin
         op = op_type'($urandom_range(0, 6));
      end
      if (fill_estimate > 0 && $urandom_range(0, 99) < 80)
         pos = POS_WIDTH'($urandom_range(0, fill_estimate - 1));
      else
         pos = POS_WIDTH'($urandom_range(0, 15));
      roll = $urandom_range(0, 9);
      val  = roll == 0 ? '0 : roll == 1 ? '1 : $urandom;
      send_command(op, pos, val);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < count; n++)
         send_random((n / 40) % 3);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue errors
      send_command(OP_POP_BACK,  4'd0, 32'h0);
      send_command(OP_POP_FRONT, 4'd0, 32'h0);
      send_command(OP_READ_AT,   4'd0, 32'h0);
      send_command(OP_WRITE_AT,  4'd0, 32'hFFFF_FFFF);
      send_command(OP_REMOVE_AT, 4'd0, 32'h0);
      // both ends, value extremes
      send_command(OP_PUSH_BACK,  4'd0, 32'h0000_0000);
      send_command(OP_PUSH_BACK,  4'd0, 32'hFFFF_FFFF);
      send_command(OP_PUSH_FRONT, 4'd0, 32'h8000_0001);
      send_command(OP_PUSH_FRONT, 4'd0, 32'h1234_5678);
      send_command(OP_READ_AT,    4'd0, 32'h0);
      send_command(OP_READ_AT,    4'd3, 32'h0);
      send_command(OP_READ_AT,    4'd4, 32'h0);
      send_command(OP_READ_AT,    4'd15, 32'h0);
      send_command(OP_WRITE_AT,   4'd2, 32'hA5A5_A5A5);
      send_command(OP_READ_AT,    4'd2, 32'h0);
      // remove from the middle, then remove the last element
      send_command(OP_REMOVE_AT,  4'd1, 32'h0);
      send_command(OP_REMOVE_AT,  4'd2, 32'h0);
      send_command(OP_POP_FRONT,  4'd0, 32'h0);
      send_command(OP_POP_BACK,   4'd0, 32'h0);
      send_command(OP_POP_BACK,   4'd0, 32'h0);
      send_command(OP_POP_FRONT,  4'd0, 32'h0);
      send_command(OP_PUSH_FRONT, 4'd15, 32'hFFFF_FFFF);

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(73, 0, PHASE_ITEMS);

      // long rsp hold-off while commands keep coming
      hold_requests++;
      run_phase(0, 0, 40);

      run_phase(0, 73, PHASE_ITEMS);
      run_phase(10, 10, PHASE_ITEMS);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
